// ===== hw/rtl/frp_pkg.sv =====
// shared types, codes and elaboration-time shape table math for the ramp profile generator
// no dependencies; used by frp_ctrl, frp_dp and the top level
package frp_pkg;

	localparam int MAX_RAMPS_DEF   = 16;
	localparam int SHAPE_DEPTH_DEF = 1024;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_EVAL   = 1'b1;

	localparam logic [1:0] SHAPE_LINEAR = 2'd0;
	localparam logic [1:0] SHAPE_EXP    = 2'd1;
	localparam logic [1:0] SHAPE_SIG    = 2'd2;

	localparam longint ONE_Q30 = longint'(1) << 30;
	localparam longint NEG_EXP_Q30 [6] = '{
		64'sd1073741824, 64'sd395007542, 64'sd145315153,
		64'sd53458458, 64'sd19666267, 64'sd7234816
	};

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_ORDER    = 3'd1,
		STAT_OVERLAP  = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_NEG_TIME = 3'd4
	} frp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_READ, ST_CHECK, ST_DIV, ST_ROM, ST_MUL, ST_ACC, ST_OUT
	} frp_state_t;

	typedef enum logic [1:0] {
		RES_ZERO, RES_INIT, RES_FINAL
	} frp_res_sel_t;

	typedef struct packed {
		logic         load;
		logic         append_wr;
		logic         scan_start;
		logic         scan_next;
		logic         res_wr;
		frp_res_sel_t res_sel;
		frp_status_t  res_status;
		logic         res_inside;
		logic         div_init;
		logic         div_step;
		logic         rom_rd;
		logic         axis_clr;
		logic         mul;
		logic         acc;
		logic         out_load;
	} frp_cmd_t;

	typedef struct packed {
		logic        is_eval;
		frp_status_t app_status;
		logic        t_neg;
		logic        count_zero;
		logic        hit;
		logic        at_start;
		logic        at_end;
		logic        scan_last;
		logic        div_last;
		logic        axis_last;
		logic        out_free;
	} frp_sts_t;

	typedef struct packed {
		logic [31:0]      t_start;
		logic [31:0]      t_end;
		logic [2:0][31:0] init;
		logic [2:0][31:0] fin;
		logic [1:0]       shape;
	} frp_entry_t;

	// shift-subtract division, only for table building at elaboration
	function automatic longint unsigned frp_udiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((n >> b) & 64'd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// exp(-n/depth) in q30, n at most 5*depth
	function automatic longint frp_neg_exp(longint unsigned n, longint unsigned depth);
		longint unsigned rem;
		int              k;
		longint          f;
		longint          sum;
		longint          term;
		bit              stop;
		rem  = n;
		k    = 0;
		stop = 1'b0;
		for (int c = 0; c < 6; c++) begin
			if (rem >= depth) begin
				rem = rem - depth;
				k   = k + 1;
			end
		end
		if (k > 5) k = 5;
		f    = longint'(frp_udiv(rem << 30, depth));
		sum  = ONE_Q30;
		term = ONE_Q30;
		for (int j = 1; j <= 40; j++) begin
			if (!stop) begin
				term = longint'(frp_udiv(longint'(unsigned'((term * f) >>> 30)),
					longint'(j)));
				if (term == 0) stop = 1'b1;
				else if (j % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
		end
		return (NEG_EXP_Q30[k] * sum) >>> 30;
	endfunction

	// one q0.16 entry of the exponential or sigmoid table
	function automatic logic [15:0] frp_shape_entry(int i, bit sig, int depth);
		longint e;
		longint x10;
		longint n;
		longint es;
		longint den;
		longint s;
		longint v;
		e   = frp_neg_exp(longint'(3 * i), longint'(depth));
		x10 = longint'(10 * i) - longint'(5 * depth);
		n   = (x10 < 0) ? -x10 : x10;
		es  = frp_neg_exp(n, longint'(depth));
		den = ONE_Q30 + es;
		s   = longint'(frp_udiv((longint'(1) << 46) + (den >>> 1), den));
		if (sig) v = (x10 >= 0) ? s : 64'sd65536 - s;
		else v = 64'sd65536 - ((e + 64'sd8192) >>> 14);
		return v[15:0];
	endfunction

endpackage

// ===== hw/rtl/frp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module frp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/frp_ctrl.sv =====
// sequencing state machine for append and evaluate beats
// depends on frp_pkg
module frp_ctrl import frp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output frp_cmd_t cmd,
	input  frp_sts_t sts
);

	frp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.res_wr  = 1'b1;
				cmd.res_sel = RES_ZERO;
				state_d     = ST_OUT;
				if (!sts.is_eval) begin
					cmd.res_status = sts.app_status;
					cmd.append_wr  = (sts.app_status == STAT_OK);
				end else if (sts.t_neg) begin
					cmd.res_status = STAT_NEG_TIME;
				end else if (!sts.count_zero) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.hit) begin
					cmd.res_wr     = 1'b1;
					cmd.res_inside = 1'b1;
					if (sts.at_start) begin
						cmd.res_sel = RES_INIT;
						state_d     = ST_OUT;
					end else if (sts.at_end) begin
						cmd.res_sel = RES_FINAL;
						state_d     = ST_OUT;
					end else begin
						cmd.res_sel  = RES_ZERO;
						cmd.div_init = 1'b1;
						state_d      = ST_DIV;
					end
				end else if (sts.scan_last) begin
					// the last entry is on the read port: its final value is the answer
					cmd.res_wr  = 1'b1;
					cmd.res_sel = RES_FINAL;
					state_d     = ST_OUT;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom_rd   = 1'b1;
				cmd.axis_clr = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.axis_last ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/frp_dp.sv =====
// ramp table, scan compare, serial divider, shape rom, blend multiplier and output register
// depends on frp_pkg and frp_ram
module frp_dp import frp_pkg::*; #(
	parameter int MAX_RAMPS   = MAX_RAMPS_DEF,
	parameter int SHAPE_DEPTH = SHAPE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  frp_cmd_t           cmd,
	output frp_sts_t           sts,
	input  logic               req_type,
	input  logic signed [31:0] ramp_begin,
	input  logic signed [31:0] ramp_finish,
	input  logic signed [31:0] initial_x,
	input  logic signed [31:0] initial_y,
	input  logic signed [31:0] initial_z,
	input  logic signed [31:0] final_x,
	input  logic signed [31:0] final_y,
	input  logic signed [31:0] final_z,
	input  logic        [1:0]  shape_kind,
	input  logic signed [31:0] query_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic signed [31:0] field_z,
	output logic        [2:0]  status,
	output logic               in_ramp
);

	localparam int AW   = (MAX_RAMPS > 1) ? $clog2(MAX_RAMPS) : 1;
	localparam int CW   = $clog2(MAX_RAMPS + 1);
	localparam int IDXW = $clog2(SHAPE_DEPTH);
	localparam int PW   = 16 + IDXW + 1;
	localparam int EW   = $bits(frp_entry_t);

	// captured request
	logic                     req_type_q;
	logic signed [31:0]       begin_q, finish_q, qtime_q;
	logic        [2:0][31:0]  init_q, fin_q;
	logic        [1:0]        shape_q;

	logic        [CW-1:0]     count_q;
	logic signed [31:0]       last_end_q;
	logic        [AW-1:0]     scan_idx_q;

	frp_entry_t               wr_ent, ent;
	logic        [EW-1:0]     rd_bits;

	logic        [33:0]       rem_q;
	logic        [15:0]       quot_q;
	logic        [3:0]        div_cnt_q;
	logic        [33:0]       rem_sh;
	logic        [33:0]       den;

	logic        [15:0]       exp_tab [SHAPE_DEPTH];
	logic        [15:0]       sig_tab [SHAPE_DEPTH];
	logic        [PW-1:0]     idx_prod;
	logic        [IDXW-1:0]   rom_idx;
	logic        [15:0]       rom_q;
	logic        [15:0]       weight;

	logic        [1:0]        axis_q;
	logic signed [32:0]       diff;
	logic signed [49:0]       prod_q;
	logic signed [49:0]       prod_shr;

	logic        [2:0][31:0]  res_q;
	frp_status_t              res_status_q;
	logic                     res_inside_q;

	logic                     out_valid_q;
	logic        [2:0][31:0]  out_field_q;
	logic        [2:0]        out_status_q;
	logic                     out_inside_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			begin_q    <= ramp_begin;
			finish_q   <= ramp_finish;
			qtime_q    <= query_time;
			init_q     <= {initial_z, initial_y, initial_x};
			fin_q      <= {final_z, final_y, final_x};
			shape_q    <= shape_kind;
		end
	end

	// fill level and end of the last ramp for the overlap check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append_wr) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append_wr) last_end_q <= finish_q;
		if (cmd.scan_start) scan_idx_q <= '0;
		else if (cmd.scan_next) scan_idx_q <= scan_idx_q + AW'(1);
	end

	always_comb begin
		wr_ent.t_start = begin_q;
		wr_ent.t_end   = finish_q;
		wr_ent.init    = init_q;
		wr_ent.fin     = fin_q;
		wr_ent.shape   = shape_q;
	end

	frp_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_RAMPS),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.append_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_ent),
		.rd_addr (scan_idx_q),
		.rd_data (rd_bits)
	);

	assign ent = frp_entry_t'(rd_bits);

	// status toward the controller
	always_comb begin
		sts.is_eval = (req_type_q == REQ_EVAL);
		if (begin_q >= finish_q) sts.app_status = STAT_ORDER;
		else if (count_q != '0 && begin_q < last_end_q) sts.app_status = STAT_OVERLAP;
		else if (count_q == CW'(MAX_RAMPS)) sts.app_status = STAT_FULL;
		else sts.app_status = STAT_OK;
		sts.t_neg      = qtime_q[31];
		sts.count_zero = (count_q == '0);
		sts.at_start   = (qtime_q <= $signed(ent.t_start));
		sts.at_end     = (qtime_q >= $signed(ent.t_end));
		sts.hit        = (qtime_q >= $signed(ent.t_start)) && (qtime_q <= $signed(ent.t_end));
		sts.scan_last  = (CW'(scan_idx_q) == count_q - CW'(1));
		sts.div_last   = (div_cnt_q == 4'd15);
		sts.axis_last  = (axis_q == 2'd2);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// restoring divider, one quotient bit a cycle: alpha = ((t - s) << 16) / (e - s)
	assign den    = 34'($signed(ent.t_end)) - 34'($signed(ent.t_start));
	assign rem_sh = {rem_q[32:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q     <= 34'(qtime_q) - 34'($signed(ent.t_start));
			quot_q    <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 4'd1;
			if (rem_sh >= den) begin
				rem_q  <= rem_sh - den;
				quot_q <= {quot_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[14:0], 1'b0};
			end
		end
	end

	// shape tables, built at elaboration
	for (genvar gi = 0; gi < SHAPE_DEPTH; gi++) begin : g_rom
		localparam logic [15:0] EXP_V = frp_shape_entry(gi, 1'b0, SHAPE_DEPTH);
		localparam logic [15:0] SIG_V = frp_shape_entry(gi, 1'b1, SHAPE_DEPTH);
		assign exp_tab[gi] = EXP_V;
		assign sig_tab[gi] = SIG_V;
	end

	assign idx_prod = PW'(quot_q) * PW'(SHAPE_DEPTH);
	assign rom_idx  = idx_prod[16 +: IDXW];

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) rom_q <= (ent.shape == SHAPE_EXP) ? exp_tab[rom_idx] : sig_tab[rom_idx];
	end

	always_comb begin
		case (ent.shape)
			SHAPE_EXP, SHAPE_SIG: weight = rom_q;
			default:              weight = quot_q;
		endcase
	end

	// blend, one axis per multiply and add pair
	assign diff     = 33'($signed(ent.fin[axis_q])) - 33'($signed(ent.init[axis_q]));
	assign prod_shr = prod_q >>> 16;

	always_ff @(posedge clk) begin
		if (cmd.axis_clr) axis_q <= '0;
		else if (cmd.acc) axis_q <= axis_q + 2'd1;
		if (cmd.mul) prod_q <= diff * $signed({1'b0, weight});
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			res_status_q <= cmd.res_status;
			res_inside_q <= cmd.res_inside;
			unique case (cmd.res_sel)
				RES_INIT:  res_q <= ent.init;
				RES_FINAL: res_q <= ent.fin;
				default:   res_q <= '0;
			endcase
		end else if (cmd.acc) begin
			res_q[axis_q] <= ent.init[axis_q] + prod_shr[31:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_field_q  <= res_q;
			out_status_q <= res_status_q;
			out_inside_q <= res_inside_q;
		end
	end

	assign out_valid = out_valid_q;
	assign field_x   = out_field_q[0];
	assign field_y   = out_field_q[1];
	assign field_z   = out_field_q[2];
	assign status    = out_status_q;
	assign in_ramp   = out_inside_q;

endmodule

// ===== hw/rtl/field_ramp_profile_generator_unit.sv =====
// top level of the three-axis field ramp profile generator
// depends on frp_pkg, frp_ctrl, frp_dp (which holds frp_ram)
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-------------------------------------------
//  in      | in        | in_valid / in_stall  | req_type, ramp times, fields, shape, time
//  out     | out       | out_valid / out_stall| field_x/y/z, status, in_ramp
//
// an append beat goes through decode and output; an evaluate beat does the same when it ends
// early (negative time, empty table), else it reads and checks each table entry scanned, and
// when the time falls strictly inside a ramp it adds 16 divider steps, a rom read and 3 mul/add
// the scan through the ramp table's one read port and the bit-serial divider set how long a beat takes
// one beat is worked on at a time; in_stall is low only while the sequencer is idle
// the result sits in an output register, so a new beat is taken while it waits
// reset clears the sequencer, the fill count and out_valid; the table is not cleared
module field_ramp_profile_generator_unit import frp_pkg::*; #(
	parameter int MAX_RAMPS   = MAX_RAMPS_DEF,
	parameter int SHAPE_DEPTH = SHAPE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [31:0] ramp_begin,
	input  logic signed [31:0] ramp_finish,
	input  logic signed [31:0] initial_x,
	input  logic signed [31:0] initial_y,
	input  logic signed [31:0] initial_z,
	input  logic signed [31:0] final_x,
	input  logic signed [31:0] final_y,
	input  logic signed [31:0] final_z,
	input  logic        [1:0]  shape_kind,
	input  logic signed [31:0] query_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic signed [31:0] field_z,
	output logic        [2:0]  status,
	output logic               in_ramp
);

	// command and status between sequencer and datapath
	frp_cmd_t cmd;
	frp_sts_t sts;

	frp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table, divider, shape rom, blend and output register
	frp_dp #(
		.MAX_RAMPS   (MAX_RAMPS),
		.SHAPE_DEPTH (SHAPE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.ramp_begin  (ramp_begin),
		.ramp_finish (ramp_finish),
		.initial_x   (initial_x),
		.initial_y   (initial_y),
		.initial_z   (initial_z),
		.final_x     (final_x),
		.final_y     (final_y),
		.final_z     (final_z),
		.shape_kind  (shape_kind),
		.query_time  (query_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_x     (field_x),
		.field_y     (field_y),
		.field_z     (field_z),
		.status      (status),
		.in_ramp     (in_ramp)
	);

endmodule
